// ===== hw/rtl/vcp_pkg.sv =====
// shared types and constants for the vertex projection block
package vcp_pkg;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int ROW_W   = 64;
  localparam int TERM_W  = 49;
  localparam int CLIP_W  = 50;
  localparam int DEN_W   = 50;
  localparam int NUM_W   = 66;
  localparam int DIM_W   = 15;
  localparam int QUO_W   = 32;
  localparam int FRONT_DEPTH = 3;
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CW    = 4;

  localparam logic [1:0] REG_ROW_X = 2'd0;
  localparam logic [1:0] REG_ROW_Y = 2'd1;
  localparam logic [1:0] REG_ROW_W = 2'd2;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW_W_RESET = 64'h0100_0000_0000_0000;

  localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [CLIP_W-1:0] cx;
    logic signed [CLIP_W-1:0] cy;
    logic signed [CLIP_W-1:0] cw;
  } clip_word_t;

  typedef struct packed {
    logic [Q_CW-1:0] level;
    logic            empty;
  } q_status_t;

endpackage

// ===== hw/rtl/vcp_front.sv =====
// front end: clip-space dot products against the three matrix rows
module vcp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [vcp_pkg::COORD_W-1:0]  in_x,
  input  logic signed [vcp_pkg::COORD_W-1:0]  in_y,
  input  logic signed [vcp_pkg::COORD_W-1:0]  in_z,
  input  logic [2:0][vcp_pkg::ROW_W-1:0]      rows,
  output logic                                out_valid,
  output vcp_pkg::clip_word_t                 out_word
);

  logic                                 v1_r, v2_r, v3_r;
  logic signed [vcp_pkg::TERM_W-1:0]    term_nxt [3][4];
  logic signed [vcp_pkg::TERM_W-1:0]    term_r   [3][4];
  logic signed [vcp_pkg::TERM_W:0]      pair_r   [3][2];
  vcp_pkg::clip_word_t                  word_r;
  logic signed [vcp_pkg::TERM_W+1:0]    sum_nxt  [3];

  // one coefficient times one coordinate for the first three terms; the fourth is the bare coefficient
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      term_nxt[r][0] = vcp_pkg::TERM_W'($signed(rows[r][15:0]) * in_x);
      term_nxt[r][1] = vcp_pkg::TERM_W'($signed(rows[r][31:16]) * in_y);
      term_nxt[r][2] = vcp_pkg::TERM_W'($signed(rows[r][47:32]) * in_z);
      term_nxt[r][3] = {{17{rows[r][63]}}, rows[r][63:48], 16'h0000};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = (vcp_pkg::TERM_W+2)'(pair_r[r][0]) + (vcp_pkg::TERM_W+2)'(pair_r[r][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        term_r[r][k] <= term_nxt[r][k];
      end
      pair_r[r][0] <= (vcp_pkg::TERM_W+1)'(term_r[r][0]) + (vcp_pkg::TERM_W+1)'(term_r[r][1]);
      pair_r[r][1] <= (vcp_pkg::TERM_W+1)'(term_r[r][2]) + (vcp_pkg::TERM_W+1)'(term_r[r][3]);
    end
    word_r.cx <= vcp_pkg::CLIP_W'(sum_nxt[0]);
    word_r.cy <= vcp_pkg::CLIP_W'(sum_nxt[1]);
    word_r.cw <= vcp_pkg::CLIP_W'(sum_nxt[2]);
  end

  assign out_valid = v3_r;
  assign out_word  = word_r;

endmodule

// ===== hw/rtl/vcp_queue.sv =====
// short fifo between the dot-product front and the divide back end
module vcp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vcp_pkg::clip_word_t push_word,
  output logic                pop_valid,
  output vcp_pkg::clip_word_t pop_word,
  output vcp_pkg::q_status_t  status
);

  vcp_pkg::clip_word_t          mem_r [vcp_pkg::Q_DEPTH];
  logic [vcp_pkg::Q_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [vcp_pkg::Q_CW-1:0]     count_r, count_nxt;
  logic                         pop;
  logic                         pop_valid_r;
  vcp_pkg::clip_word_t          pop_word_r;

  assign pop = (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      pop_valid_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r     <= count_nxt;
      pop_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
    pop_word_r <= mem_r[rd_ptr_r];
  end

  assign pop_valid    = pop_valid_r;
  assign pop_word     = pop_word_r;
  assign status.level = count_r;
  assign status.empty = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (count_r == vcp_pkg::Q_CW'(vcp_pkg::Q_DEPTH))))
    else $error("queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= vcp_pkg::Q_CW'(vcp_pkg::Q_DEPTH))
    else $error("queue count out of range");

  a_pop_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |=> pop_valid_r)
    else $error("queued word not delivered");

endmodule

// ===== hw/rtl/vcp_back.sv =====
// back end: hidden test, viewport scale and pipelined q16.16 divide
module vcp_back #(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  vcp_pkg::clip_word_t                in_word,
  output logic                               out_valid,
  output logic [vcp_pkg::QUO_W-1:0]          out_sx,
  output logic [vcp_pkg::QUO_W-1:0]          out_sy,
  output logic                               out_vis
);

  localparam int NSTG = vcp_pkg::QUO_W;
  localparam int PIPE = 5 + NSTG;
  localparam logic [vcp_pkg::DIM_W-1:0] DIM [2] = '{
    vcp_pkg::DIM_W'(SCREEN_WIDTH), vcp_pkg::DIM_W'(SCREEN_HEIGHT)};

  logic [PIPE-1:0]                        v_r;
  logic [PIPE-1:0]                        vis_r;
  logic [vcp_pkg::DEN_W-1:0]              den_r  [NSTG+4];

  logic signed [vcp_pkg::CLIP_W:0]        n1_r   [2];
  logic [47:0]                            plo_r  [2];
  logic signed [34:0]                     phi_r  [2];
  logic signed [vcp_pkg::NUM_W-1:0]       num_r  [2];
  logic                                   neg_r  [2][PIPE];
  logic [vcp_pkg::NUM_W-1:0]              mag_r  [2];
  logic                                   sat_r  [2][PIPE];
  logic [vcp_pkg::DEN_W-1:0]              rem_r  [2][NSTG+1];
  logic [15:0]                            low_r  [2][NSTG+1];
  logic [vcp_pkg::QUO_W-1:0]              quo_r  [2][NSTG+1];
  logic [vcp_pkg::DEN_W:0]                trial  [2][NSTG];
  logic [vcp_pkg::QUO_W-1:0]              res_nxt [2];
  logic [vcp_pkg::QUO_W-1:0]              res_r  [2];
  logic                                   ov_r, vo_r;

  // restoring step: one quotient bit per stage, numerator bits shift in
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < NSTG; s++) begin
        trial[l][s] = {rem_r[l][s], (s < 16) ? low_r[l][s][15] : 1'b0};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (sat_r[l][PIPE-1]) begin
        res_nxt[l] = neg_r[l][PIPE-1] ? vcp_pkg::SAT_NEG : vcp_pkg::SAT_POS;
      end else if (neg_r[l][PIPE-1]) begin
        res_nxt[l] = (quo_r[l][NSTG] > vcp_pkg::SAT_NEG) ? vcp_pkg::SAT_NEG
                                                          : (~quo_r[l][NSTG] + 1'b1);
      end else begin
        res_nxt[l] = (quo_r[l][NSTG] > vcp_pkg::SAT_POS) ? vcp_pkg::SAT_POS
                                                          : quo_r[l][NSTG];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[PIPE-2:0], in_valid};
      vo_r <= v_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    // stage 0: hidden test, numerators and denominator
    vis_r[0] <= (in_word.cw > 0);
    den_r[0] <= {in_word.cw[vcp_pkg::DEN_W-2:0], 1'b0};
    n1_r[0]  <= (vcp_pkg::CLIP_W+1)'(in_word.cx) + (vcp_pkg::CLIP_W+1)'(in_word.cw);
    n1_r[1]  <= (vcp_pkg::CLIP_W+1)'(in_word.cw) - (vcp_pkg::CLIP_W+1)'(in_word.cy);
    for (int p = 1; p < PIPE; p++) begin
      vis_r[p] <= vis_r[p-1];
    end
    for (int p = 1; p < NSTG + 4; p++) begin
      den_r[p] <= den_r[p-1];
    end
    for (int l = 0; l < 2; l++) begin
      // stage 1: split scale multiply
      plo_r[l] <= 48'({1'b0, n1_r[l][31:0]} * {1'b0, DIM[l]});
      phi_r[l] <= 35'($signed(n1_r[l][vcp_pkg::CLIP_W:32]) * $signed({1'b0, DIM[l]}));
      // stage 2: recombine
      num_r[l] <= (vcp_pkg::NUM_W'(phi_r[l]) <<< 32) + vcp_pkg::NUM_W'(plo_r[l]);
      // stage 3: sign and magnitude
      neg_r[l][3] <= num_r[l][vcp_pkg::NUM_W-1];
      mag_r[l]    <= num_r[l][vcp_pkg::NUM_W-1] ? vcp_pkg::NUM_W'(-num_r[l])
                                                 : vcp_pkg::NUM_W'(num_r[l]);
      // stage 4: integer part overflow and initial remainder
      neg_r[l][4] <= neg_r[l][3];
      sat_r[l][4] <= (mag_r[l][vcp_pkg::NUM_W-1:16] >= den_r[3]);
      rem_r[l][0] <= mag_r[l][vcp_pkg::NUM_W-1:16];
      low_r[l][0] <= mag_r[l][15:0];
      quo_r[l][0] <= '0;
      for (int p = 5; p < PIPE; p++) begin
        neg_r[l][p] <= neg_r[l][p-1];
        sat_r[l][p] <= sat_r[l][p-1];
      end
      for (int s = 0; s < NSTG; s++) begin
        if (trial[l][s] >= {1'b0, den_r[4+s]}) begin
          rem_r[l][s+1] <= vcp_pkg::DEN_W'(trial[l][s] - {1'b0, den_r[4+s]});
          quo_r[l][s+1] <= {quo_r[l][s][vcp_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_r[l][s+1] <= vcp_pkg::DEN_W'(trial[l][s]);
          quo_r[l][s+1] <= {quo_r[l][s][vcp_pkg::QUO_W-2:0], 1'b0};
        end
        low_r[l][s+1] <= {low_r[l][s][14:0], 1'b0};
      end
      res_r[l] <= vis_r[PIPE-1] ? res_nxt[l] : '0;
    end
    ov_r <= vis_r[PIPE-1];
  end

  assign out_valid = vo_r;
  assign out_sx    = res_r[0];
  assign out_sy    = res_r[1];
  assign out_vis   = ov_r;

endmodule

// ===== hw/rtl/vertex_clip_project_viewport.sv =====
// top level: vertex clip transform, perspective divide and viewport map
// Takes one world point (signed q16.16 x, y, z) per clock when start is high and
// busy is low, and gives one screen point per point taken, in order, on
// out_strobe for a single cycle; the receiver cannot stall. Throughput is one
// word per clock. Each point passes the dot-product front end, the queue and the
// back end, its depth set by the 32-stage restoring divider that forms the 16
// integer and 16 fraction bits of each quotient. busy rises only if the queue
// nears full, which never happens since the back end drains every cycle. The user
// must write matrix rows (cfg_we/cfg_index/cfg_data) only while idle (not enforced).
module vertex_clip_project_viewport #(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vcp_pkg::COORD_W-1:0]  in_world_x,
  input  logic signed [vcp_pkg::COORD_W-1:0]  in_world_y,
  input  logic signed [vcp_pkg::COORD_W-1:0]  in_world_z,
  // result word
  output logic                                out_strobe,
  output logic signed [vcp_pkg::COORD_W-1:0]  out_screen_x,
  output logic signed [vcp_pkg::COORD_W-1:0]  out_screen_y,
  output logic                                out_visible,
  // configuration
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [vcp_pkg::ROW_W-1:0]           cfg_data
);

  logic [2:0][vcp_pkg::ROW_W-1:0] rows_r;
  logic                           accept;
  logic                           f_valid;
  vcp_pkg::clip_word_t            f_word;
  logic                           q_valid;
  vcp_pkg::clip_word_t            q_word;
  vcp_pkg::q_status_t             q_status;
  logic [vcp_pkg::QUO_W-1:0]      sx, sy;

  // matrix row registers; an index past the last row is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= vcp_pkg::ROW_X_RESET;
      rows_r[1] <= vcp_pkg::ROW_Y_RESET;
      rows_r[2] <= vcp_pkg::ROW_W_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vcp_pkg::REG_ROW_X: rows_r[0] <= cfg_data;
        vcp_pkg::REG_ROW_Y: rows_r[1] <= cfg_data;
        vcp_pkg::REG_ROW_W: rows_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off while the queue could not absorb what the front end has in flight
  assign busy   = (q_status.level >= vcp_pkg::Q_CW'(vcp_pkg::Q_DEPTH - vcp_pkg::FRONT_DEPTH));
  assign accept = start && !busy;

  vcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_x      (in_world_x),
    .in_y      (in_world_y),
    .in_z      (in_world_z),
    .rows      (rows_r),
    .out_valid (f_valid),
    .out_word  (f_word)
  );

  vcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_word (f_word),
    .pop_valid (q_valid),
    .pop_word  (q_word),
    .status    (q_status)
  );

  vcp_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_word   (q_word),
    .out_valid (out_strobe),
    .out_sx    (sx),
    .out_sy    (sy),
    .out_vis   (out_visible)
  );

  assign out_screen_x = $signed(sx);
  assign out_screen_y = $signed(sy);

  // hidden points come out as zero
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_visible) |-> (out_screen_x == '0 && out_screen_y == '0))
    else $error("hidden point with nonzero coordinates");

  // the back end drains every cycle, so the block never stalls its source
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("unexpected back pressure");

  // an accepted word leaves the front end after its term, pair and word registers
  a_front_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 f_valid)
    else $error("front end lost a word");

endmodule
